// ----- hdl/sfh_pkg.sv -----
// Shared types and constants for the sync frame header receiver.
`default_nettype none

package sfh_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int DATA_W         = 32;
    localparam int ADDR_W         = 3;

    localparam logic [CFG_W-1:0] HDR_TO_RESET = 16'd3000;
    localparam logic [CFG_W-1:0] SUB_TO_RESET = 16'd2000;

    localparam logic [7:0] SYNC_A = 8'hAA;
    localparam logic [7:0] SYNC_B = 8'h55;
    localparam logic [7:0] TYPE_D = 8'h44;
    localparam int HEADER_BYTES   = 5;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_FOUND       = 2'd0,
        ST_HDR_TIMEOUT = 2'd1,
        ST_SUB_TIMEOUT = 2'd2
    } t_status;

    typedef enum logic {
        REG_HDR_TO = 1'b0,
        REG_SUB_TO = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] hdr_to;
        logic [CFG_W-1:0] sub_to;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic [7:0]  frame_type;
        logic [7:0]  sub_type;
        logic [31:0] payload_len;
    } t_result;

endpackage

`default_nettype wire

// ----- hdl/sfh_cfg_regs.sv -----
// APB register block holding the header and sub-type timeout limits.
`default_nettype none

module sfh_cfg_regs
    import sfh_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    logic [CFG_W-1:0] r_hdr_to;
    logic [CFG_W-1:0] r_sub_to;
    logic             wr_en;
    t_reg_idx         reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_to <= HDR_TO_RESET;
            r_sub_to <= SUB_TO_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_HDR_TO: r_hdr_to <= pwdata[CFG_W-1:0];
                REG_SUB_TO: r_sub_to <= pwdata[CFG_W-1:0];
                default:    r_hdr_to <= r_hdr_to;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_HDR_TO: prdata = DATA_W'(r_hdr_to);
            REG_SUB_TO: prdata = DATA_W'(r_sub_to);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg.hdr_to = r_hdr_to;
    assign o_cfg.sub_to = r_sub_to;

endmodule

`default_nettype wire

// ----- hdl/sfh_core.sv -----
// Header hunt state machine: sync search, header collection and tick timers.
`default_nettype none

module sfh_core
    import sfh_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [1:0] i_cmd,
    input  wire logic [7:0] i_rx_byte,
    input  t_cfg            i_cfg,
    output logic            o_push,
    output t_result         o_result
);

    localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SYNC1,
        PH_SYNC2,
        PH_COLLECT,
        PH_SUBTYPE
    } t_phase;

    t_phase                r_phase,   n_phase;
    logic [2:0]            r_count,   n_count;
    logic [7:0]            r_type,    n_type;
    logic [31:0]           r_len,     n_len;
    logic [TIMER_BITS-1:0] r_elapsed, n_elapsed;

    t_cmd                  cmd;
    logic [TIMER_BITS-1:0] elapsed_inc;
    logic [CW-1:0]         elapsed_ext;
    logic [31:0]           len_merged;
    logic [1:0]            lane;

    assign cmd         = t_cmd'(i_cmd);
    assign elapsed_inc = (r_elapsed == {TIMER_BITS{1'b1}}) ?
                         r_elapsed : r_elapsed + TIMER_BITS'(1);
    assign elapsed_ext = CW'(elapsed_inc);
    assign lane        = r_count[1:0] - 2'd1;
    assign len_merged  = r_len | (32'(i_rx_byte) << {lane, 3'b000});

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_type    = r_type;
        n_len     = r_len;
        n_elapsed = r_elapsed;
        o_push    = 1'b0;
        o_result  = '{status: ST_FOUND, frame_type: 8'd0, sub_type: 8'd0,
                      payload_len: 32'd0};

        if (i_accept) begin
            if (cmd == CMD_START) begin
                n_phase   = PH_SYNC1;
                n_count   = '0;
                n_type    = '0;
                n_len     = '0;
                n_elapsed = '0;
                if (i_cfg.hdr_to == '0) begin
                    o_push          = 1'b1;
                    o_result.status = ST_HDR_TIMEOUT;
                    n_phase         = PH_IDLE;
                end
            end else if (r_phase != PH_IDLE && cmd == CMD_TICK) begin
                n_elapsed = elapsed_inc;
                if (r_phase == PH_SUBTYPE) begin
                    if (elapsed_ext > CW'(i_cfg.sub_to)) begin
                        o_push          = 1'b1;
                        o_result.status = ST_SUB_TIMEOUT;
                        n_phase         = PH_IDLE;
                    end
                end else if (elapsed_ext >= CW'(i_cfg.hdr_to)) begin
                    o_push          = 1'b1;
                    o_result.status = ST_HDR_TIMEOUT;
                    n_phase         = PH_IDLE;
                end
            end else if (r_phase != PH_IDLE && cmd == CMD_BYTE) begin
                case (r_phase)
                    PH_SYNC1: begin
                        if (i_rx_byte == SYNC_A) n_phase = PH_SYNC2;
                    end
                    PH_SYNC2: begin
                        if (i_rx_byte == SYNC_B) begin
                            n_phase = PH_COLLECT;
                            n_count = '0;
                            n_type  = '0;
                            n_len   = '0;
                        end else begin
                            n_phase = PH_SYNC1;
                        end
                    end
                    PH_COLLECT: begin
                        if (r_count == '0) n_type = i_rx_byte;
                        else               n_len  = len_merged;
                        n_count = r_count + 3'd1;
                        if (r_count == 3'(HEADER_BYTES - 1)) begin
                            if (r_type == TYPE_D) begin
                                n_phase   = PH_SUBTYPE;
                                n_elapsed = '0;
                            end else begin
                                o_push               = 1'b1;
                                o_result.frame_type  = r_type;
                                o_result.payload_len = len_merged;
                                n_phase              = PH_IDLE;
                            end
                        end
                    end
                    PH_SUBTYPE: begin
                        o_push               = 1'b1;
                        o_result.frame_type  = r_type;
                        o_result.sub_type    = i_rx_byte;
                        o_result.payload_len = r_len - 32'd1;
                        n_phase              = PH_IDLE;
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_count   <= '0;
            r_type    <= '0;
            r_len     <= '0;
            r_elapsed <= '0;
        end else begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_type    <= n_type;
            r_len     <= n_len;
            r_elapsed <= n_elapsed;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sfh_out_queue.sv -----
// Two-entry result buffer: output register plus skid register.
`default_nettype none

module sfh_out_queue
    import sfh_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_result   i_result,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_result   o_result
);

    logic    r_out_v, n_out_v;
    logic    r_skd_v, n_skd_v;
    t_result r_out,   n_out;
    t_result r_skd,   n_skd;
    logic    out_free;

    assign out_free = !r_out_v || !i_stall;

    always_comb begin
        n_out_v = r_out_v;
        n_skd_v = r_skd_v;
        n_out   = r_out;
        n_skd   = r_skd;
        if (out_free) begin
            if (r_skd_v) begin
                n_out_v = 1'b1;
                n_out   = r_skd;
                n_skd_v = 1'b0;
            end else begin
                n_out_v = i_push;
                n_out   = i_result;
            end
        end else if (i_push) begin
            n_skd_v = 1'b1;
            n_skd   = i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_skd_v <= 1'b0;
        end else begin
            r_out_v <= n_out_v;
            r_skd_v <= n_skd_v;
        end
        r_out <= n_out;
        r_skd <= n_skd;
    end

    assign o_full   = r_skd_v;
    assign o_valid  = r_out_v;
    assign o_result = r_out;

endmodule

`default_nettype wire

// ----- hdl/sync_frame_header_receiver.sv -----
// Top level of the sync-word frame header receiver.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-------------------------------
//  request  | in        | i_in_valid / o_in_stall  | i_cmd, i_rx_byte
//  result   | out       | o_out_valid / i_out_stall| o_status, o_frame_type,
//           |           |                          | o_sub_type, o_payload_len
//  config   | in        | APB psel/penable/pready  | paddr, pwdata, prdata
//
// One request per cycle while o_in_stall is low; a result is registered in the result buffer.
// All work is one combinational pass of the header state machine into the result registers.
// A two-entry result buffer lets requests flow while a result waits; o_in_stall rises only
// when both entries hold results.
// Synchronous active-low reset: state machine idle, limits at 3000 and 2000 ticks.
`default_nettype none

module sync_frame_header_receiver
    import sfh_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_cmd,
    input  wire logic [7:0]        i_rx_byte,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [1:0]        o_status,
    output logic      [7:0]        o_frame_type,
    output logic      [7:0]        o_sub_type,
    output logic      [31:0]       o_payload_len,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    t_cfg    cfg;
    t_result core_result;
    t_result out_result;
    logic    core_push;
    logic    accept;

    assign accept = i_in_valid && !o_in_stall;

    sfh_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sfh_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_cmd     (i_cmd),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (cfg),
        .o_push    (core_push),
        .o_result  (core_result)
    );

    sfh_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (core_push),
        .i_result (core_result),
        .o_full   (o_in_stall),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_result)
    );

    assign o_status      = out_result.status;
    assign o_frame_type  = out_result.frame_type;
    assign o_sub_type    = out_result.sub_type;
    assign o_payload_len = out_result.payload_len;

endmodule

`default_nettype wire

// ----- tb/sfh_header_checker.sv -----
// Request/result monitor, header predictor and result comparison for the frame header receiver.
`default_nettype none

module sfh_header_checker
    import sfh_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_stall,
    input  wire logic [1:0]        i_cmd,
    input  wire logic [7:0]        i_rx_byte,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_stall,
    input  wire logic [1:0]        i_status,
    input  wire logic [7:0]        i_frame_type,
    input  wire logic [7:0]        i_sub_type,
    input  wire logic [31:0]       i_payload_len,
    input  wire logic              i_psel,
    input  wire logic              i_penable,
    input  wire logic              i_pwrite,
    input  wire logic              i_pready,
    input  wire logic [ADDR_W-1:0] i_paddr,
    input  wire logic [DATA_W-1:0] i_pwdata,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_found,
    output int                     o_hdr_timeouts,
    output int                     o_sub_timeouts
);

    typedef enum logic [2:0] {
        HUNT_IDLE,
        HUNT_SYNC1,
        HUNT_SYNC2,
        HUNT_COLLECT,
        HUNT_SUBTYPE
    } t_hunt;

    localparam logic [TIMER_BITS_DEF-1:0] TICKS_MAX = '1;

    t_cfg                      limits;
    t_hunt                     hunt;
    logic [2:0]                hdr_count;
    logic [7:0]                hdr_type;
    logic [31:0]               hdr_len;
    logic [TIMER_BITS_DEF-1:0] ticks;
    t_result                   expected_headers[$];
    int                        fails;
    int                        found;
    int                        hdr_timeouts;
    int                        sub_timeouts;

    task automatic predict_header(input t_cmd c, input logic [7:0] b);
        t_result r;
        bit      emit;
        r    = '0;
        emit = 1'b0;
        if (c == CMD_START) begin
            hunt      = HUNT_SYNC1;
            hdr_count = '0;
            hdr_type  = '0;
            hdr_len   = '0;
            ticks     = '0;
            if (limits.hdr_to == '0) begin
                r.status = ST_HDR_TIMEOUT;
                emit     = 1'b1;
            end
        end else if (hunt != HUNT_IDLE && c == CMD_TICK) begin
            if (ticks != TICKS_MAX)
                ticks = ticks + 1'b1;
            if (hunt == HUNT_SUBTYPE) begin
                if (ticks > limits.sub_to) begin
                    r.status = ST_SUB_TIMEOUT;
                    emit     = 1'b1;
                end
            end else if (ticks >= limits.hdr_to) begin
                r.status = ST_HDR_TIMEOUT;
                emit     = 1'b1;
            end
        end else if (hunt != HUNT_IDLE && c == CMD_BYTE) begin
            case (hunt)
                HUNT_SYNC1: begin
                    if (b == SYNC_A)
                        hunt = HUNT_SYNC2;
                end
                HUNT_SYNC2: begin
                    if (b == SYNC_B) begin
                        hunt      = HUNT_COLLECT;
                        hdr_count = '0;
                        hdr_type  = '0;
                        hdr_len   = '0;
                    end else begin
                        hunt = HUNT_SYNC1;
                    end
                end
                HUNT_COLLECT: begin
                    if (hdr_count == '0)
                        hdr_type = b;
                    else
                        hdr_len |= {24'd0, b} << (8 * (int'(hdr_count) - 1));
                    hdr_count = hdr_count + 1'b1;
                    if (hdr_count >= HEADER_BYTES) begin
                        if (hdr_type == TYPE_D) begin
                            hunt  = HUNT_SUBTYPE;
                            ticks = '0;
                        end else begin
                            r.status      = ST_FOUND;
                            r.frame_type  = hdr_type;
                            r.payload_len = hdr_len;
                            emit          = 1'b1;
                        end
                    end
                end
                HUNT_SUBTYPE: begin
                    r.status      = ST_FOUND;
                    r.frame_type  = hdr_type;
                    r.sub_type    = b;
                    r.payload_len = hdr_len - 32'd1;
                    emit          = 1'b1;
                end
                default: hunt = HUNT_IDLE;
            endcase
        end
        if (emit) begin
            hunt = HUNT_IDLE;
            expected_headers.push_back(r);
        end
    endtask

    function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
        if (got === want)
            return 1'b1;
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        bit      ok;
        if (!i_rst_n) begin
            limits.hdr_to = HDR_TO_RESET;
            limits.sub_to = SUB_TO_RESET;
            hunt          = HUNT_IDLE;
            hdr_count     = '0;
            hdr_type      = '0;
            hdr_len       = '0;
            ticks         = '0;
            expected_headers.delete();
            fails         = 0;
            found         = 0;
            hdr_timeouts  = 0;
            sub_timeouts  = 0;
        end else begin
            // a result is always registered after its request is taken: compare first
            if (i_out_valid && !i_out_stall) begin
                if (expected_headers.size() == 0) begin
                    $error("result with no request pending: status %0d type 0x%0h",
                           i_status, i_frame_type);
                    fails++;
                end else begin
                    want = expected_headers.pop_front();
                    ok = field_ok("status", 32'(want.status), 32'(i_status))
                       & field_ok("frame_type", 32'(want.frame_type), 32'(i_frame_type))
                       & field_ok("sub_type", 32'(want.sub_type), 32'(i_sub_type))
                       & field_ok("payload_len", want.payload_len, i_payload_len);
                    if (!ok)
                        fails++;
                    case (want.status)
                        ST_FOUND:       found++;
                        ST_HDR_TIMEOUT: hdr_timeouts++;
                        default:        sub_timeouts++;
                    endcase
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_header(t_cmd'(i_cmd), i_rx_byte);
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[2]))
                    REG_HDR_TO: limits.hdr_to = i_pwdata[CFG_W-1:0];
                    REG_SUB_TO: limits.sub_to = i_pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending      <= expected_headers.size();
        o_fail_count   <= fails;
        o_found        <= found;
        o_hdr_timeouts <= hdr_timeouts;
        o_sub_timeouts <= sub_timeouts;
    end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Top of the frame header receiver testbench: clock, reset, stimulus, limits and verdict.
`default_nettype none

module testbench;
    import sfh_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_REQUESTS = 2000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        cmd;
    logic [7:0]        rx_byte;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        status;
    logic [7:0]        frame_type;
    logic [7:0]        sub_type;
    logic [31:0]       payload_len;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending;
    int found;
    int hdr_timeouts;
    int sub_timeouts;
    int requests;
    int limit_writes;
    int cycles;
    int tick_pct;
    int long_hold;
    int send_calm_left;
    bit send_calm;
    bit gap_free;

    sync_frame_header_receiver uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_cmd         (cmd),
        .i_rx_byte     (rx_byte),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_status      (status),
        .o_frame_type  (frame_type),
        .o_sub_type    (sub_type),
        .o_payload_len (payload_len),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    sfh_header_checker hdr_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_cmd          (cmd),
        .i_rx_byte      (rx_byte),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_status       (status),
        .i_frame_type   (frame_type),
        .i_sub_type     (sub_type),
        .i_payload_len  (payload_len),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_found        (found),
        .o_hdr_timeouts (hdr_timeouts),
        .o_sub_timeouts (sub_timeouts)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    // result side: random stall per result, plus a long hold-off on request
    initial begin
        int stall_left;
        int calm_left;
        bit calm;
        stall_left = 0;
        calm_left  = 0;
        calm       = 1'b0;
        out_stall  = 1'b0;
        forever begin
            @(negedge clk);
            if (long_hold > 0) begin
                stall_left = long_hold;
                long_hold  = 0;
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
                @(posedge clk);
                if (out_valid) begin
                    if (calm_left == 0) begin
                        calm      = ($urandom_range(0, 3) == 0);
                        calm_left = $urandom_range(5, 40);
                    end
                    calm_left--;
                    stall_left = calm ? 0 : $urandom_range(0, 17);
                end
            end
        end
    end

    task automatic send_request(input t_cmd c, input logic [7:0] b);
        int gap;
        if (gap_free) begin
            gap = 0;
        end else begin
            if (send_calm_left == 0) begin
                send_calm      = ($urandom_range(0, 3) == 0);
                send_calm_left = $urandom_range(10, 80);
            end
            send_calm_left--;
            gap = send_calm ? 0 : $urandom_range(0, 17);
        end
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        requests++;
    endtask

    // a byte request, with ticks and the odd unused command slipped in ahead of it
    task automatic send_rx(input logic [7:0] b);
        while ($urandom_range(1, 100) <= tick_pct)
            send_request(CMD_TICK, 8'($urandom));
        if ($urandom_range(0, 49) == 0)
            send_request(CMD_NONE, 8'($urandom));
        send_request(CMD_BYTE, b);
    endtask

    task automatic send_frame();
        logic [7:0]  ftype;
        logic [31:0] len;
        int          shape;
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
            repeat ($urandom_range(1, 6))
                send_request(t_cmd'($urandom_range(0, 3)), 8'($urandom));
            return;
        end
        send_request(CMD_START, 8'($urandom));
        repeat ($urandom_range(0, 2)) send_rx(8'($urandom));
        if (shape == 1) begin
            send_rx(SYNC_A);
            send_rx(SYNC_A);
            send_rx(8'($urandom));
        end
        if (shape == 2) begin
            send_rx(SYNC_A);
            send_rx(SYNC_B);
            send_rx(8'($urandom));
            send_request(CMD_START, 8'($urandom));
        end
        send_rx(SYNC_A);
        send_rx(SYNC_B);
        case ($urandom_range(0, 5))
            0, 1:    ftype = TYPE_D;
            2:       ftype = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
            default: ftype = 8'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       len = '0;
            1:       len = '1;
            2:       len = $urandom_range(1, 3);
            default: len = $urandom;
        endcase
        send_rx(ftype);
        for (int i = 0; i < 4; i++)
            send_rx(len[8*i +: 8]);
        if (shape == 3)
            repeat ($urandom_range(1, 12)) send_request(CMD_TICK, 8'($urandom));
        if (ftype == TYPE_D)
            send_rx(8'($urandom));
        repeat ($urandom_range(0, 1)) send_rx(8'($urandom));
    endtask

    task automatic write_limit(input t_reg_idx idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        limit_writes++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return CFG_W'($urandom_range(1, 4));
            3:       return CFG_W'($urandom_range(5, 40));
            4:       return CFG_W'($urandom_range(41, 300));
            default: return CFG_W'($urandom);
        endcase
    endfunction

    initial begin
        logic [CFG_W-1:0] hdr_limit;
        logic [CFG_W-1:0] sub_limit;
        int               phase_end;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        cmd            = CMD_START;
        rx_byte        = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        requests       = 0;
        limit_writes   = 0;
        tick_pct       = 0;
        long_hold      = 0;
        send_calm_left = 0;
        send_calm      = 1'b0;
        gap_free       = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // idle block ignores everything but a start
        send_request(CMD_BYTE, SYNC_A);
        send_request(CMD_TICK, 8'h00);
        send_request(CMD_NONE, 8'hFF);
        // doubled 0xAA loses sync; then a 'D' header of zero length wraps to all ones
        send_request(CMD_START, 8'h00);
        send_request(CMD_BYTE, SYNC_A);
        send_request(CMD_BYTE, SYNC_A);
        send_request(CMD_BYTE, SYNC_B);
        send_request(CMD_BYTE, SYNC_A);
        send_request(CMD_BYTE, SYNC_B);
        send_request(CMD_BYTE, TYPE_D);
        send_request(CMD_BYTE, 8'h00);
        send_request(CMD_BYTE, 8'h00);
        send_request(CMD_NONE, 8'h00);
        send_request(CMD_TICK, 8'h00);
        send_request(CMD_BYTE, 8'h00);
        send_request(CMD_BYTE, 8'h00);
        send_request(CMD_BYTE, 8'hFF);
        // plain header with all-ones fields
        send_request(CMD_START, 8'hFF);
        send_request(CMD_BYTE, SYNC_A);
        send_request(CMD_BYTE, SYNC_B);
        send_request(CMD_BYTE, 8'hFF);
        repeat (4) send_request(CMD_BYTE, 8'hFF);
        send_request(CMD_BYTE, 8'h12);

        // zero header limit: every start times out at once; hold results to back up requests
        drain_results();
        write_limit(REG_HDR_TO, '0);
        long_hold = 300;
        gap_free  = 1'b1;
        repeat (24) send_request(CMD_START, 8'($urandom));
        gap_free  = 1'b0;

        for (int p = 0; p < 8; p++) begin
            drain_results();
            case (p)
                0: begin
                    hdr_limit = '0;
                    sub_limit = '1;
                end
                1: begin
                    hdr_limit = '1;
                    sub_limit = '0;
                end
                2: begin
                    hdr_limit = 16'd3;
                    sub_limit = 16'd1;
                end
                3: begin
                    hdr_limit = 16'd1;
                    sub_limit = 16'd2;
                end
                default: begin
                    hdr_limit = pick_limit();
                    sub_limit = pick_limit();
                end
            endcase
            write_limit(REG_HDR_TO, hdr_limit);
            write_limit(REG_SUB_TO, sub_limit);
            tick_pct  = (p < 4) ? $urandom_range(10, 30) : $urandom_range(0, 35);
            phase_end = requests + RANDOM_REQUESTS / 8;
            while (requests < phase_end)
                send_frame();
        end

        drain_results();
        repeat (8) @(posedge clk);
        $display("summary: %0d requests, %0d limit writes, %0d mismatching results",
                 requests, limit_writes, fail_count);
        $display("summary: %0d headers found, %0d header timeouts, %0d sub-type timeouts",
                 found, hdr_timeouts, sub_timeouts);
        if (fail_count == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
hdl/sfh_pkg.sv
hdl/sfh_cfg_regs.sv
hdl/sfh_core.sv
hdl/sfh_out_queue.sv
hdl/sync_frame_header_receiver.sv
tb/sfh_header_checker.sv
tb/testbench.sv
